// ===== sv/rsbu_pkg.sv =====
package rsbu_pkg;

    // Operation groups
    typedef enum logic [1:0] {
        OP_ROTATE = 2'd0,
        OP_BIT    = 2'd1,
        OP_RES    = 2'd2,
        OP_SET    = 2'd3
    } op_t;

    // Rotate / shift kinds, selected by bit_select in the rotate group
    typedef enum logic [2:0] {
        ROT_RLC = 3'd0,
        ROT_RRC = 3'd1,
        ROT_RL  = 3'd2,
        ROT_RR  = 3'd3,
        ROT_SLA = 3'd4,
        ROT_SRA = 3'd5,
        ROT_SLL = 3'd6,
        ROT_SRL = 3'd7
    } rot_kind_t;

    localparam int unsigned DATA_W  = 8;
    localparam int unsigned TDATA_W = 16;
    localparam int unsigned S_USER_W = 6;
    localparam int unsigned M_USER_W = 1;

    localparam logic [DATA_W-1:0] SIGN_MASK = 8'h80;
    localparam logic [DATA_W-1:0] LSB_ONE   = 8'h01;

    // One accepted input word, unpacked
    typedef struct packed {
        op_t                operation;
        logic [2:0]         bit_select;
        logic               accumulator_form;
        logic [DATA_W-1:0]  operand;
        logic               carry_in;
        logic               sign_in;
        logic               zero_in;
        logic               parity_in;
    } in_word_t;

    // One result word, unpacked
    typedef struct packed {
        logic [DATA_W-1:0]  result;
        logic               write_back;
        logic               carry_out;
        logic               sign_out;
        logic               zero_out;
        logic               parity_out;
    } out_word_t;

    // Pipeline handshake between the two register stages
    typedef struct packed {
        logic valid;
        logic advance;
    } stage_ctl_t;

endpackage

// ===== sv/rsbu_in_stage.sv =====
module rsbu_in_stage (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rsbu_pkg::TDATA_W-1:0]  s_tdata,
    input  logic [rsbu_pkg::S_USER_W-1:0] s_tuser,
    input  logic                          advance,
    output rsbu_pkg::in_word_t            word,
    output logic                          valid
);
    import rsbu_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_word_t word_reg;
    in_word_t word_unpacked;
    logic     load;

    // Take a new word when empty or when the held word moves on
    assign s_tready = !valid_reg || advance;
    assign load     = s_tvalid && s_tready;

    // Unpack stream fields
    always_comb
    begin
        word_unpacked.operation        = op_t'(s_tuser[1:0]);
        word_unpacked.bit_select       = s_tuser[4:2];
        word_unpacked.accumulator_form = s_tuser[5];
        word_unpacked.operand          = s_tdata[7:0];
        word_unpacked.carry_in         = s_tdata[8];
        word_unpacked.sign_in          = s_tdata[9];
        word_unpacked.zero_in          = s_tdata[10];
        word_unpacked.parity_in        = s_tdata[11];
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= word_unpacked;
        end
    end

    assign word  = word_reg;
    assign valid = valid_reg;

endmodule

// ===== sv/rsbu_alu.sv =====
module rsbu_alu (
    input  rsbu_pkg::in_word_t  word,
    output rsbu_pkg::out_word_t res
);
    import rsbu_pkg::*;

    logic [DATA_W-1:0] d;
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] rot;
    logic              rot_c;
    logic              short_form;

    assign d          = word.operand;
    assign mask       = LSB_ONE << word.bit_select;
    assign short_form = word.accumulator_form && !word.bit_select[2];

    // Rotate / shift network
    always_comb
    begin
        rot   = d;
        rot_c = d[0];
        unique case (rot_kind_t'(word.bit_select))
            ROT_RLC: begin rot = {d[6:0], d[7]};            rot_c = d[7]; end
            ROT_RRC: begin rot = {d[0], d[7:1]};            rot_c = d[0]; end
            ROT_RL:  begin rot = {d[6:0], word.carry_in};   rot_c = d[7]; end
            ROT_RR:  begin rot = {word.carry_in, d[7:1]};   rot_c = d[0]; end
            ROT_SLA: begin rot = {d[6:0], 1'b0};            rot_c = d[7]; end
            ROT_SRA: begin rot = (d >> 1) | (d & SIGN_MASK); rot_c = d[0]; end
            ROT_SLL: begin rot = {d[6:0], 1'b0} | LSB_ONE;  rot_c = d[7]; end
            ROT_SRL: begin rot = {1'b0, d[7:1]};            rot_c = d[0]; end
            default: begin rot = d;                         rot_c = d[0]; end
        endcase
    end

    // Group select and flag update
    always_comb
    begin
        res.result     = d;
        res.write_back = 1'b1;
        res.carry_out  = word.carry_in;
        res.sign_out   = word.sign_in;
        res.zero_out   = word.zero_in;
        res.parity_out = word.parity_in;
        unique case (word.operation)
            OP_ROTATE:
            begin
                res.result    = rot;
                res.carry_out = rot_c;
                if (!short_form)
                begin
                    res.sign_out   = rot[7];
                    res.zero_out   = (rot == '0);
                    res.parity_out = ~(^rot);
                end
            end
            OP_BIT:
            begin
                res.write_back = 1'b0;
                res.zero_out   = ((d & mask) == '0);
            end
            OP_RES:
            begin
                res.result = d & ~mask;
            end
            OP_SET:
            begin
                res.result = d | mask;
            end
            default:
            begin
                res.result = d;
            end
        endcase
    end

endmodule

// ===== sv/rsbu_out_stage.sv =====
module rsbu_out_stage (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rsbu_pkg::stage_ctl_t          up,
    input  rsbu_pkg::out_word_t           res,
    output logic                          ready,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rsbu_pkg::TDATA_W-1:0]  m_tdata,
    output logic [rsbu_pkg::M_USER_W-1:0] m_tuser
);
    import rsbu_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_word_t res_reg;
    logic      load;

    // Result register frees up when empty or when its word is taken
    assign ready = !valid_reg || m_tready;
    assign load  = up.valid && up.advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    // Pack the result word
    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'b0000, res_reg.parity_out, res_reg.zero_out,
                       res_reg.sign_out, res_reg.carry_out, res_reg.result};
    assign m_tuser  = res_reg.write_back;

endmodule

// ===== sv/rotate_shift_bit_unit_top.sv =====
// Channel  | Dir | tdata (low bit up)                                  | tuser (low bit up)
// ---------+-----+-----------------------------------------------------+-----------------------
// s_       | in  | operand[7:0], carry_in, sign_in, zero_in, parity_in | operation[1:0],
//          |     | then 4 zero bits                                    | bit_select[2:0], acc
// m_       | out | result[7:0], carry_out, sign_out, zero_out,         | write_back
//          |     | parity_out, then 4 zero bits                        |
//
// Two register stages: input register, then bit logic, then result register.
// A word accepted into the input register is loaded into the result register once
// that register has room; one word per cycle while the output is not stalled.
// A stalled result register backs up into the input register; the input
// keeps accepting while either stage has room.
// rst_n clears both valid bits asynchronously; payload is not reset.
module rotate_shift_bit_unit_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // operand, carry_in, sign_in, zero_in, parity_in, pad
    input  logic [5:0]  s_tuser,  // operation, bit_select, accumulator_form
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,  // result, carry_out, sign_out, zero_out, parity_out, pad
    output logic [0:0]  m_tuser   // write_back
);
    import rsbu_pkg::*;

    in_word_t   in_word;
    out_word_t  alu_res;
    stage_ctl_t ctl;
    logic       in_valid;
    logic       out_ready;

    assign ctl.valid   = in_valid;
    assign ctl.advance = out_ready;

    // Input register
    rsbu_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .advance  (out_ready),
        .word     (in_word),
        .valid    (in_valid)
    );

    // Bit operation logic
    rsbu_alu u_alu (
        .word (in_word),
        .res  (alu_res)
    );

    // Result register
    rsbu_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .up       (ctl),
        .res      (alu_res),
        .ready    (out_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Empty input register always takes a word
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid |-> s_tready)
        else $error("input stalled with empty input register");

    // A word that can move forward shows up at the output next cycle
    a_forward: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && (!m_tvalid || m_tready)) |=> m_tvalid)
        else $error("word lost between stages");

    // Both stages full and output stalled: no new word
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while pipe is full");

    // A bit test never writes back and never changes the byte
    a_bit_test: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_word.operation == OP_BIT) |->
            (!alu_res.write_back && alu_res.result == in_word.operand))
        else $error("bit test altered the operand");

endmodule

// ===== dv/rotate_shift_bit_unit_top_test.sv =====
module rotate_shift_bit_unit_top_test;
    import rsbu_pkg::*;

    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned WORDS_PER_RUN  = 670;
    localparam int unsigned DRAIN_CYCLES   = 8;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // operand[7:0], carry_in, sign_in, zero_in, parity_in, pad
    logic [5:0]  s_tuser;   // operation[1:0], bit_select[2:0], accumulator_form
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;   // result[7:0], carry_out, sign_out, zero_out, parity_out, pad
    logic [0:0]  m_tuser;   // write_back

    // Predicted words waiting for the output, oldest first
    out_word_t   op_results_due[$];
    int unsigned mismatch_count = 0;

    // Idle rates in percent, set per test
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;

    // Long output hold-off: test bumps the request, receiver counts it down
    int unsigned hold_request = 0;
    int unsigned hold_taken   = 0;
    int unsigned hold_left    = 0;

    rotate_shift_bit_unit_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 clk = ~clk;

    // Expected output word for one input word
    function automatic out_word_t compute_bit_op(in_word_t w);
        out_word_t         r;
        logic [DATA_W-1:0] d;
        logic [DATA_W-1:0] mask;
        d            = w.operand;
        mask         = LSB_ONE << w.bit_select;
        r.result     = d;
        r.write_back = 1'b1;
        r.carry_out  = w.carry_in;
        r.sign_out   = w.sign_in;
        r.zero_out   = w.zero_in;
        r.parity_out = w.parity_in;
        case (w.operation)
            OP_ROTATE:
            begin
                case (rot_kind_t'(w.bit_select))
                    ROT_RLC: r.result = {d[6:0], d[7]};
                    ROT_RRC: r.result = {d[0], d[7:1]};
                    ROT_RL:  r.result = {d[6:0], w.carry_in};
                    ROT_RR:  r.result = {w.carry_in, d[7:1]};
                    ROT_SLA: r.result = {d[6:0], 1'b0};
                    ROT_SRA: r.result = {d[7], d[7:1]};
                    ROT_SLL: r.result = {d[6:0], 1'b1};
                    default: r.result = {1'b0, d[7:1]};
                endcase
                // left kinds shift out bit 7, right kinds bit 0
                case (rot_kind_t'(w.bit_select))
                    ROT_RLC, ROT_RL, ROT_SLA, ROT_SLL: r.carry_out = d[7];
                    default:                           r.carry_out = d[0];
                endcase
                // short accumulator rotates touch carry only
                if (!(w.accumulator_form && rot_kind_t'(w.bit_select) < ROT_SLA))
                begin
                    r.sign_out   = (r.result & SIGN_MASK) != 0;
                    r.zero_out   = (r.result == 0);
                    r.parity_out = ~^r.result;
                end
            end
            OP_BIT:
            begin
                r.write_back = 1'b0;
                r.zero_out   = ((d & mask) == 0);
            end
            OP_RES:  r.result = d & ~mask;
            default: r.result = d | mask;
        endcase
        return r;
    endfunction

    function automatic in_word_t make_word(op_t op, logic [2:0] sel, logic acc,
                                           logic [7:0] operand, logic [3:0] flags);
        in_word_t w;
        w.operation        = op;
        w.bit_select       = sel;
        w.accumulator_form = acc;
        w.operand          = operand;
        {w.parity_in, w.zero_in, w.sign_in, w.carry_in} = flags;
        return w;
    endfunction

    function automatic in_word_t random_word();
        return make_word(op_t'($urandom_range(3)), 3'($urandom_range(7)),
                         1'($urandom_range(1)), 8'($urandom_range(255)),
                         4'($urandom_range(15)));
    endfunction

    // Offer one word, wait for the handshake, then queue its prediction
    task automatic send_word(in_word_t w);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, w.parity_in, w.zero_in, w.sign_in, w.carry_in, w.operand};
        s_tuser  <= {w.accumulator_form, w.bit_select, w.operation};
        do
            @(posedge clk);
        while (!s_tready);
        op_results_due.insert(op_results_due.size(), compute_bit_op(w));
    endtask

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // Output side: random ready, or a long counted hold-off on request
    always @(posedge clk)
    begin
        if (hold_request != hold_taken)
        begin
            hold_taken <= hold_request;
            hold_left  <= HOLD_CYCLES;
            m_tready   <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Compare each accepted output word with the oldest prediction
    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (op_results_due.size() == 0)
            begin
                $error("unexpected output word: tdata 0x%0h, tuser 0x%0h", m_tdata, m_tuser);
                mismatch_count++;
            end
            else
            begin
                want = op_results_due.pop_front();
                check_field("result", want.result, m_tdata[7:0]);
                check_field("write_back", 8'(want.write_back), 8'(m_tuser[0]));
                check_field("carry_out", 8'(want.carry_out), 8'(m_tdata[8]));
                check_field("sign_out", 8'(want.sign_out), 8'(m_tdata[9]));
                check_field("zero_out", 8'(want.zero_out), 8'(m_tdata[10]));
                check_field("parity_out", 8'(want.parity_out), 8'(m_tdata[11]));
            end
        end
    end

    // Corner words: every kind in both forms, bit ops at bit 0 and 7
    task automatic test_directed_edges();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        // long form; operands chosen so shifts wrap or clear to zero
        for (int k = 0; k < 8; k++)
            send_word(make_word(OP_ROTATE, 3'(k), 1'b0, (k % 2) ? 8'h01 : 8'h80,
                                (k % 4 < 2) ? 4'b0000 : 4'b1111));
        // accumulator form, carry-only kinds
        for (int k = 0; k < 4; k++)
            send_word(make_word(OP_ROTATE, 3'(k), 1'b1, (k < 2) ? 8'hFF : 8'h00, 4'b1011));
        // accumulator flag ignored for the shift kinds
        for (int k = 4; k < 8; k++)
            send_word(make_word(OP_ROTATE, 3'(k), 1'b1, 8'hC0, 4'b0100));
        send_word(make_word(OP_BIT, 3'd0, 1'b0, 8'h00, 4'b1111));
        send_word(make_word(OP_BIT, 3'd7, 1'b1, 8'hFF, 4'b0000));
        send_word(make_word(OP_RES, 3'd7, 1'b0, 8'hFF, 4'b0101));
        send_word(make_word(OP_RES, 3'd0, 1'b1, 8'h01, 4'b1010));
        send_word(make_word(OP_SET, 3'd0, 1'b0, 8'h00, 4'b0000));
        send_word(make_word(OP_SET, 3'd7, 1'b1, 8'h7F, 4'b1111));
    endtask

    task automatic test_random_slow_output();
        tx_idle_pct = 14;
        rx_idle_pct = 85;
        repeat (WORDS_PER_RUN) send_word(random_word());
    endtask

    task automatic test_random_slow_input();
        tx_idle_pct = 85;
        rx_idle_pct = 14;
        repeat (WORDS_PER_RUN) send_word(random_word());
    endtask

    // Output held off while input keeps offering: both stages fill and input stalls
    task automatic test_output_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_request++;
        repeat (40) send_word(random_word());
    endtask

    task automatic test_random_full_rate();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (WORDS_PER_RUN) send_word(random_word());
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        test_random_slow_output();
        test_random_slow_input();
        test_output_backpressure();
        test_random_full_rate();
        s_tvalid <= 1'b0;

        // drain, then give any stray word time to show up
        while (op_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("rotate_shift_bit_unit_top: match");
        else
            $display("rotate_shift_bit_unit_top: mismatch");
        $finish;
    end

    // Watchdog
    initial
    begin
        #1600000;
        $display("rotate_shift_bit_unit_top: mismatch");
        $finish;
    end

endmodule
